// ===== sv/sctu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sctu_pkg
// shared widths, key codes, result kinds and flag types of the scan decoder
// ----------------------------------------------------------------------------
package sctu_pkg;

   localparam int SCAN_W    = 8;
   localparam int KIND_W    = 2;
   localparam int CHAR_W    = 16;
   localparam int SPECIAL_W = 8;
   localparam int INDEX_W   = 7;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_NONE    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CHAR    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SPECIAL = 2'd2;

   // scan codes with a meaning of their own
   localparam logic [SCAN_W-1:0] KEY_PREFIX         = 8'hE0;
   localparam logic [SCAN_W-1:0] KEY_ALT            = 8'h38;
   localparam logic [SCAN_W-1:0] KEY_TAB            = 8'h0F;
   localparam logic [SCAN_W-1:0] KEY_CAPS           = 8'h3A;
   localparam logic [SCAN_W-1:0] KEY_LEFT_SHIFT     = 8'h2A;
   localparam logic [SCAN_W-1:0] KEY_RIGHT_SHIFT    = 8'h36;
   localparam logic [SCAN_W-1:0] KEY_UP             = 8'h48;
   localparam logic [SCAN_W-1:0] KEY_RIGHT          = 8'h4D;
   localparam logic [SCAN_W-1:0] KEY_LEFT           = 8'h4B;
   localparam logic [SCAN_W-1:0] KEY_DOWN           = 8'h50;
   localparam logic [SCAN_W-1:0] KEY_LEFT_SHIFT_UP  = 8'hAA;
   localparam logic [SCAN_W-1:0] KEY_RIGHT_SHIFT_UP = 8'hB6;
   localparam int                RELEASE_BIT        = 7;

   // case offset between upper and lower letters
   localparam logic [CHAR_W-1:0] CASE_DELTA = 16'd32;

   typedef struct packed {
      logic shift_held;
      logic caps_on;
      logic layout_russian;
   } sctu_flags_type;

endpackage

// ===== sv/sctu_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sctu_req_if / sctu_rsp_if
// valid/ready channels carrying scan bytes in and decoded results out
// ----------------------------------------------------------------------------
interface sctu_req_if;
   logic                          valid;
   logic                          ready;
   logic [sctu_pkg::SCAN_W-1:0]   scan_code;

   modport source (output valid, output scan_code, input ready);
   modport sink   (input valid, input scan_code, output ready);
endinterface

interface sctu_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [sctu_pkg::KIND_W-1:0]    result_kind;
   logic [sctu_pkg::CHAR_W-1:0]    char_code;
   logic [sctu_pkg::SPECIAL_W-1:0] special_code;

   modport source (output valid, output result_kind, output char_code,
                   output special_code, input ready);
   modport sink   (input valid, input result_kind, input char_code,
                   input special_code, output ready);
endinterface

// ===== sv/sctu_lookup.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sctu_lookup
// character tables by layout and shift, followed by the caps lock case swap
// ----------------------------------------------------------------------------
module sctu_lookup (
   input  logic [sctu_pkg::INDEX_W-1:0] key_index,
   input  sctu_pkg::sctu_flags_type     flags,
   output logic [sctu_pkg::CHAR_W-1:0]  char_code
);

   function automatic logic [sctu_pkg::CHAR_W-1:0] en_plain(
      input logic [sctu_pkg::INDEX_W-1:0] idx);
      logic [sctu_pkg::CHAR_W-1:0] c;
      case (idx)
         7'h1E: c = 16'h0061;  7'h30: c = 16'h0062;  7'h2E: c = 16'h0063;
         7'h20: c = 16'h0064;  7'h12: c = 16'h0065;  7'h21: c = 16'h0066;
         7'h22: c = 16'h0067;  7'h23: c = 16'h0068;  7'h17: c = 16'h0069;
         7'h24: c = 16'h006A;  7'h25: c = 16'h006B;  7'h26: c = 16'h006C;
         7'h32: c = 16'h006D;  7'h31: c = 16'h006E;  7'h18: c = 16'h006F;
         7'h19: c = 16'h0070;  7'h10: c = 16'h0071;  7'h13: c = 16'h0072;
         7'h1F: c = 16'h0073;  7'h14: c = 16'h0074;  7'h16: c = 16'h0075;
         7'h2F: c = 16'h0076;  7'h11: c = 16'h0077;  7'h2D: c = 16'h0078;
         7'h15: c = 16'h0079;  7'h2C: c = 16'h007A;
         7'h0B: c = 16'h0030;  7'h02: c = 16'h0031;  7'h03: c = 16'h0032;
         7'h04: c = 16'h0033;  7'h05: c = 16'h0034;  7'h06: c = 16'h0035;
         7'h07: c = 16'h0036;  7'h08: c = 16'h0037;  7'h09: c = 16'h0038;
         7'h0A: c = 16'h0039;
         7'h1C: c = 16'h000A;  7'h39: c = 16'h0020;  7'h1A: c = 16'h005B;
         7'h1B: c = 16'h005D;  7'h33: c = 16'h002C;  7'h34: c = 16'h002E;
         7'h35: c = 16'h002F;  7'h27: c = 16'h003B;  7'h28: c = 16'h0027;
         7'h29: c = 16'h0060;  7'h2B: c = 16'h005C;  7'h0F: c = 16'h0009;
         7'h0C: c = 16'h002D;  7'h0D: c = 16'h003D;  7'h0E: c = 16'h0008;
         default: c = '0;
      endcase
      return c;
   endfunction

   function automatic logic [sctu_pkg::CHAR_W-1:0] en_shifted(
      input logic [sctu_pkg::INDEX_W-1:0] idx);
      logic [sctu_pkg::CHAR_W-1:0] c;
      case (idx)
         7'h02: c = 16'h0021;  7'h03: c = 16'h0040;  7'h04: c = 16'h0023;
         7'h05: c = 16'h0024;  7'h06: c = 16'h0025;  7'h07: c = 16'h005E;
         7'h08: c = 16'h0026;  7'h09: c = 16'h002A;  7'h0A: c = 16'h0028;
         7'h0B: c = 16'h0029;  7'h0C: c = 16'h005F;  7'h0D: c = 16'h002B;
         7'h1A: c = 16'h007B;  7'h1B: c = 16'h007D;  7'h2B: c = 16'h007C;
         7'h33: c = 16'h003C;  7'h34: c = 16'h003E;  7'h35: c = 16'h003F;
         7'h29: c = 16'h007E;  7'h27: c = 16'h003A;  7'h28: c = 16'h0022;
         default: c = '0;
      endcase
      return c;
   endfunction

   function automatic logic [sctu_pkg::CHAR_W-1:0] ru_plain(
      input logic [sctu_pkg::INDEX_W-1:0] idx);
      logic [sctu_pkg::CHAR_W-1:0] c;
      case (idx)
         7'h1E: c = 16'h0444;  7'h30: c = 16'h0438;  7'h2E: c = 16'h0441;
         7'h20: c = 16'h0432;  7'h12: c = 16'h0443;  7'h21: c = 16'h0430;
         7'h22: c = 16'h043F;  7'h23: c = 16'h0440;  7'h17: c = 16'h0448;
         7'h24: c = 16'h043E;  7'h25: c = 16'h043B;  7'h26: c = 16'h0434;
         7'h32: c = 16'h044C;  7'h31: c = 16'h0442;  7'h18: c = 16'h0449;
         7'h19: c = 16'h0437;  7'h10: c = 16'h0439;  7'h13: c = 16'h043A;
         7'h1F: c = 16'h044B;  7'h14: c = 16'h0435;  7'h16: c = 16'h0433;
         7'h2F: c = 16'h043C;  7'h11: c = 16'h0446;  7'h2D: c = 16'h0447;
         7'h15: c = 16'h043D;  7'h2C: c = 16'h044F;  7'h1A: c = 16'h0445;
         7'h1B: c = 16'h044A;  7'h33: c = 16'h0431;  7'h34: c = 16'h044E;
         7'h29: c = 16'h0451;  7'h27: c = 16'h0436;  7'h28: c = 16'h044D;
         7'h0B: c = 16'h0030;  7'h02: c = 16'h0031;  7'h03: c = 16'h0032;
         7'h04: c = 16'h0033;  7'h05: c = 16'h0034;  7'h06: c = 16'h0035;
         7'h07: c = 16'h0036;  7'h08: c = 16'h0037;  7'h09: c = 16'h0038;
         7'h0A: c = 16'h0039;
         7'h1C: c = 16'h000A;  7'h39: c = 16'h0020;  7'h0F: c = 16'h0009;
         7'h0C: c = 16'h002D;  7'h0D: c = 16'h003D;  7'h0E: c = 16'h0008;
         7'h2B: c = 16'h005C;  7'h35: c = 16'h002E;
         default: c = '0;
      endcase
      return c;
   endfunction

   function automatic logic [sctu_pkg::CHAR_W-1:0] ru_shifted(
      input logic [sctu_pkg::INDEX_W-1:0] idx);
      logic [sctu_pkg::CHAR_W-1:0] c;
      case (idx)
         7'h1E: c = 16'h0424;  7'h30: c = 16'h0418;  7'h2E: c = 16'h0421;
         7'h20: c = 16'h0412;  7'h12: c = 16'h0423;  7'h21: c = 16'h0410;
         7'h22: c = 16'h041F;  7'h23: c = 16'h0420;  7'h17: c = 16'h0428;
         7'h24: c = 16'h041E;  7'h25: c = 16'h041B;  7'h26: c = 16'h0414;
         7'h32: c = 16'h042C;  7'h31: c = 16'h0422;  7'h18: c = 16'h0429;
         7'h19: c = 16'h0417;  7'h10: c = 16'h0419;  7'h13: c = 16'h041A;
         7'h1F: c = 16'h042B;  7'h14: c = 16'h0415;  7'h16: c = 16'h0413;
         7'h2F: c = 16'h041C;  7'h11: c = 16'h0426;  7'h2D: c = 16'h0427;
         7'h15: c = 16'h041D;  7'h2C: c = 16'h042F;  7'h1A: c = 16'h0425;
         7'h1B: c = 16'h042A;  7'h33: c = 16'h0411;  7'h34: c = 16'h042E;
         7'h29: c = 16'h0401;  7'h27: c = 16'h0416;  7'h28: c = 16'h042D;
         7'h02: c = 16'h0021;  7'h03: c = 16'h0022;  7'h04: c = 16'h2116;
         7'h05: c = 16'h003B;  7'h06: c = 16'h0025;  7'h07: c = 16'h003A;
         7'h08: c = 16'h003F;  7'h09: c = 16'h002A;  7'h0A: c = 16'h0028;
         7'h0B: c = 16'h0029;  7'h0C: c = 16'h005F;  7'h0D: c = 16'h002B;
         7'h2B: c = 16'h002F;  7'h35: c = 16'h002C;
         default: c = '0;
      endcase
      return c;
   endfunction

   function automatic logic [sctu_pkg::CHAR_W-1:0] swap_case(
      input logic [sctu_pkg::CHAR_W-1:0] c);
      logic [sctu_pkg::CHAR_W-1:0] r;
      if (c >= 16'h0041 && c <= 16'h005A) begin
         r = c + sctu_pkg::CASE_DELTA;
      end else if (c >= 16'h0061 && c <= 16'h007A) begin
         r = c - sctu_pkg::CASE_DELTA;
      end else if (c >= 16'h0410 && c <= 16'h042F) begin
         r = c + sctu_pkg::CASE_DELTA;
      end else if (c >= 16'h0430 && c <= 16'h044F) begin
         r = c - sctu_pkg::CASE_DELTA;
      end else if (c == 16'h0401) begin
         r = 16'h0451;
      end else if (c == 16'h0451) begin
         r = 16'h0401;
      end else begin
         r = c;
      end
      return r;
   endfunction

   logic [sctu_pkg::CHAR_W-1:0] table_char;

   always_comb begin
      case ({flags.layout_russian, flags.shift_held})
         2'b00:   table_char = en_plain(key_index);
         2'b01:   table_char = en_shifted(key_index);
         2'b10:   table_char = ru_plain(key_index);
         2'b11:   table_char = ru_shifted(key_index);
         default: table_char = '0;
      endcase
   end

   assign char_code = flags.caps_on ? swap_case(table_char) : table_char;

endmodule

// ===== sv/scancode_to_unicode_decoder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scancode_to_unicode_decoder_unit
// set-1 scan byte to unicode character / special key decoder with modifiers
// ----------------------------------------------------------------------------
//  channel  dir  handshake     payload
//  req_ch   in   valid/ready   scan_code[7:0]
//  rsp_ch   out  valid/ready   result_kind[1:0], char_code[15:0],
//                              special_code[7:0]
//
//  one item per cycle sustained while rsp_ch.ready is high; each item's result
//  appears in the cycle after it is accepted, held in a single output register
//  synchronous active-high reset clears the modifier flags and the output
//  valid; no clearing pass
//  req_ch.ready drops only while a result waits and rsp_ch.ready is low
// ----------------------------------------------------------------------------
module scancode_to_unicode_decoder_unit (
   input  logic              clock,
   input  logic              reset,
   sctu_req_if.sink          req_ch,
   sctu_rsp_if.source        rsp_ch
);

   // modifier flags
   logic shift_held_ff, shift_held_in;
   logic caps_on_ff, caps_on_in;
   logic alt_on_ff, alt_on_in;
   logic layout_russian_ff, layout_russian_in;

   // output register
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [sctu_pkg::KIND_W-1:0]         result_kind_ff, result_kind_in;
   logic [sctu_pkg::CHAR_W-1:0]         char_code_ff, char_code_in;
   logic [sctu_pkg::SPECIAL_W-1:0]      special_code_ff, special_code_in;

   logic                                accept;
   logic [sctu_pkg::SCAN_W-1:0]         scan;
   logic [sctu_pkg::CHAR_W-1:0]         table_char;
   sctu_pkg::sctu_flags_type            flags;

   // take a new item whenever the output register is empty or being drained
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign scan         = req_ch.scan_code;

   assign flags.shift_held     = shift_held_ff;
   assign flags.caps_on        = caps_on_ff;
   assign flags.layout_russian = layout_russian_ff;

   sctu_lookup u_lookup (
      .key_index (scan[sctu_pkg::INDEX_W-1:0]),
      .flags     (flags),
      .char_code (table_char)
   );

   // decode: flag updates and the result of the current scan byte
   always_comb begin
      shift_held_in     = shift_held_ff;
      caps_on_in        = caps_on_ff;
      alt_on_in         = alt_on_ff;
      layout_russian_in = layout_russian_ff;
      result_kind_in    = sctu_pkg::KIND_NONE;
      char_code_in      = '0;
      special_code_in   = '0;

      case (scan)
         sctu_pkg::KEY_PREFIX: begin
            // extended prefix: a KIND_NONE result out, nothing changes
         end
         sctu_pkg::KEY_ALT: begin
            alt_on_in       = !alt_on_ff;
            // alt with shift held swaps the layout
            if (shift_held_ff) begin
               layout_russian_in = !layout_russian_ff;
            end
            result_kind_in  = sctu_pkg::KIND_SPECIAL;
            special_code_in = scan;
         end
         sctu_pkg::KEY_CAPS: begin
            caps_on_in      = !caps_on_ff;
            result_kind_in  = sctu_pkg::KIND_SPECIAL;
            special_code_in = scan;
         end
         sctu_pkg::KEY_TAB,
         sctu_pkg::KEY_UP,
         sctu_pkg::KEY_RIGHT,
         sctu_pkg::KEY_LEFT,
         sctu_pkg::KEY_DOWN: begin
            result_kind_in  = sctu_pkg::KIND_SPECIAL;
            special_code_in = scan;
         end
         sctu_pkg::KEY_LEFT_SHIFT,
         sctu_pkg::KEY_RIGHT_SHIFT: begin
            shift_held_in   = 1'b1;
            result_kind_in  = sctu_pkg::KIND_SPECIAL;
            special_code_in = scan;
         end
         sctu_pkg::KEY_LEFT_SHIFT_UP,
         sctu_pkg::KEY_RIGHT_SHIFT_UP: begin
            shift_held_in   = 1'b0;
            // shift release while alt is on also swaps the layout
            if (alt_on_ff) begin
               layout_russian_in = !layout_russian_ff;
            end
            result_kind_in  = sctu_pkg::KIND_SPECIAL;
            special_code_in = scan;
         end
         default: begin
            // other releases and empty table entries give a KIND_NONE result
            if (!scan[sctu_pkg::RELEASE_BIT] && table_char != '0) begin
               result_kind_in = sctu_pkg::KIND_CHAR;
               char_code_in   = table_char;
            end
         end
      endcase
   end

   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         shift_held_ff     <= 1'b0;
         caps_on_ff        <= 1'b0;
         alt_on_ff         <= 1'b0;
         layout_russian_ff <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            shift_held_ff     <= shift_held_in;
            caps_on_ff        <= caps_on_in;
            alt_on_ff         <= alt_on_in;
            layout_russian_ff <= layout_russian_in;
         end
      end
   end

   // result payload, loaded with each accepted item
   always_ff @(posedge clock) begin
      if (accept) begin
         result_kind_ff  <= result_kind_in;
         char_code_ff    <= char_code_in;
         special_code_ff <= special_code_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.result_kind  = result_kind_ff;
   assign rsp_ch.char_code    = char_code_ff;
   assign rsp_ch.special_code = special_code_ff;

endmodule
